### rtl/glz_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// glz_pkg
// Shared types and constants for the GIF LZW encoder.
// ----------------------------------------------------------------------------
package glz_pkg;

   localparam int HashSlots = 8192;
   localparam int HashBits  = $clog2(HashSlots);
   localparam int MaxCodes  = 4096;
   localparam int MaxWidth  = 12;
   localparam int TagBits   = 8;
   localparam int KeyBits   = 20;
   localparam int AccBits   = 24;
   localparam logic [HashBits-1:0] HashMul = HashBits'(32'h9E3779B1);

   typedef struct packed {
      logic [7:0] pixel_index;
      logic       last_pixel;
   } req_type;

   typedef struct packed {
      logic [7:0] code_byte;
      logic       last_byte;
   } rsp_type;

   typedef struct packed {
      logic [7:0] k;
      logic       last;
   } item_type;

   typedef struct packed {
      logic [TagBits-1:0] tag;
      logic [KeyBits-1:0] key;
      logic [11:0]        code;
   } entry_type;

endpackage
`default_nettype wire

### rtl/glz_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// glz_front
// Input queue: accepts pixel words, masks the index and holds two entries.
// ----------------------------------------------------------------------------
module glz_front (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 push,
   output logic                full,
   input  glz_pkg::req_type    req_item,
   input  wire  [3:0]          min_bits,
   output logic                item_valid,
   input  wire                 item_pop,
   output glz_pkg::item_type   item
);
   import glz_pkg::*;

   item_type   slot_ff [2];
   item_type   slot_in [2];
   logic [1:0] count_ff, count_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic [7:0] mask;
   logic       do_push, do_pop;

   assign mask       = 8'((9'd1 << min_bits) - 9'd1);
   assign full       = (count_ff == 2'd2);
   assign item_valid = (count_ff != 2'd0);
   assign item       = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = item_pop && item_valid;

   always_comb begin
      slot_in[0] = slot_ff[0];
      slot_in[1] = slot_ff[1];
      if (do_push) begin
         slot_in[wr_ptr_ff] = '{k: req_item.pixel_index & mask, last: req_item.last_pixel};
      end
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      slot_ff[0] <= slot_in[0];
      slot_ff[1] <= slot_in[1];
      if (reset) begin
         count_ff  <= '0;
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
      end
   end

endmodule
`default_nettype wire

### rtl/glz_out_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// glz_out_fifo
// Result queue of four packed code bytes.
// ----------------------------------------------------------------------------
module glz_out_fifo (
   input  wire                clock,
   input  wire                reset,
   input  wire                wr_en,
   input  glz_pkg::rsp_type   wr_word,
   output logic               wr_full,
   output logic               empty,
   input  wire                pop,
   output glz_pkg::rsp_type   rsp_item
);
   import glz_pkg::*;

   rsp_type    mem_ff [4];
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [2:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign wr_full  = (count_ff == 3'd4);
   assign empty    = (count_ff == 3'd0);
   assign rsp_item = mem_ff[rd_ptr_ff];
   assign do_push  = wr_en && !wr_full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + 2'(do_push);
      rd_ptr_in = rd_ptr_ff + 2'(do_pop);
      count_in  = count_ff + 3'(do_push) - 3'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_word;
      end
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

### rtl/glz_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// glz_back
// Dictionary engine: hashed lookup with linear probing, code assignment,
// width growth and LSB-first bit packing into bytes.
// ----------------------------------------------------------------------------
module glz_back (
   input  wire                clock,
   input  wire                reset,
   input  wire                csr_we,
   input  wire  [3:0]         csr_wdata,
   output logic [3:0]         min_bits,
   input  wire                item_valid,
   output logic               item_pop,
   input  glz_pkg::item_type  item,
   output logic               out_wr,
   output glz_pkg::rsp_type   out_word,
   input  wire                out_full
);
   import glz_pkg::*;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_PROBE, S_INSERT, S_RESTART, S_TAIL,
      S_END1, S_PUT, S_DRAIN, S_END2
   } state_type;

   entry_type          dict_mem [HashSlots];
   entry_type          rd_ff;
   logic               mem_we;
   logic [HashBits-1:0] mem_waddr, raddr;
   entry_type          mem_wdata;

   state_type           state_ff, state_in, ret_ff, ret_in, clr_next_ff, clr_next_in;
   logic [3:0]          min_ff, min_in;
   logic [7:0]          k_ff, k_in;
   logic                last_ff, last_in;
   logic                fin_ff, fin_in;
   logic                started_ff, started_in;
   logic [11:0]         prefix_ff, prefix_in;
   logic [12:0]         nfc_ff, nfc_in;
   logic [3:0]          width_ff, width_in;
   logic [AccBits-1:0]  acc_ff, acc_in;
   logic [4:0]          cnt_ff, cnt_in;
   logic [TagBits-1:0]  epoch_ff, epoch_in;
   logic [HashBits-1:0] h_ff, h_in, clr_idx_ff, clr_idx_in;
   logic [11:0]         code_ff, code_in;

   logic [3:0]          eff_min;
   logic [8:0]          clear_sym;
   logic [KeyBits-1:0]  key_new, key_cur;
   logic [HashBits-1:0] hash;
   logic [12:0]         nfc_inc;
   logic                hit_valid;

   always_comb begin
      eff_min = min_ff;
      if (min_ff < 4'd2) eff_min = 4'd2;
      else if (min_ff > 4'd8) eff_min = 4'd8;
   end

   assign min_bits   = eff_min;
   assign clear_sym  = 9'd1 << eff_min;
   assign key_new    = {prefix_ff, item.k};
   assign key_cur    = {prefix_ff, k_ff};
   assign hash       = HashBits'(key_new[HashBits-1:0] * HashMul);
   assign nfc_inc    = nfc_ff + 13'd1;
   assign hit_valid  = (rd_ff.tag == epoch_ff);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         dict_mem[mem_waddr] <= mem_wdata;
      end
      rd_ff <= dict_mem[raddr];
   end

   always_comb begin
      state_in    = state_ff;
      ret_in      = ret_ff;
      clr_next_in = clr_next_ff;
      min_in      = min_ff;
      k_in        = k_ff;
      last_in     = last_ff;
      fin_in      = fin_ff;
      started_in  = started_ff;
      prefix_in   = prefix_ff;
      nfc_in      = nfc_ff;
      width_in    = width_ff;
      acc_in      = acc_ff;
      cnt_in      = cnt_ff;
      epoch_in    = epoch_ff;
      h_in        = h_ff;
      clr_idx_in  = clr_idx_ff;
      code_in     = code_ff;
      item_pop    = 1'b0;
      out_wr      = 1'b0;
      out_word    = '{code_byte: acc_ff[7:0], last_byte: 1'b0};
      mem_we      = 1'b0;
      mem_waddr   = h_ff;
      mem_wdata   = '{tag: epoch_ff, key: key_cur, code: nfc_ff[11:0]};
      raddr       = h_ff;

      // hold the minimum size for the whole frame
      if (csr_we && !started_ff) begin
         min_in = csr_wdata;
      end

      unique case (state_ff)
         S_CLEAR: begin
            mem_we     = 1'b1;
            mem_waddr  = clr_idx_ff;
            mem_wdata  = '0;
            clr_idx_in = clr_idx_ff + HashBits'(1);
            if (&clr_idx_ff) begin
               state_in = clr_next_ff;
            end
         end
         S_IDLE: begin
            if (item_valid) begin
               item_pop = 1'b1;
               k_in     = item.k;
               last_in  = item.last;
               fin_in   = 1'b0;
               if (!started_ff) begin
                  started_in = 1'b1;
                  prefix_in  = 12'(item.k);
                  nfc_in     = 13'(clear_sym) + 13'd2;
                  width_in   = eff_min + 4'd1;
                  acc_in     = '0;
                  cnt_in     = '0;
                  code_in    = 12'(clear_sym);
                  ret_in     = S_TAIL;
                  if (&epoch_ff) begin
                     epoch_in    = TagBits'(1);
                     clr_idx_in  = '0;
                     clr_next_in = S_PUT;
                     state_in    = S_CLEAR;
                  end else begin
                     epoch_in = epoch_ff + TagBits'(1);
                     state_in = S_PUT;
                  end
               end else begin
                  h_in     = hash;
                  raddr    = hash;
                  state_in = S_PROBE;
               end
            end
         end
         S_PROBE: begin
            if (hit_valid && rd_ff.key == key_cur) begin
               prefix_in = rd_ff.code;
               state_in  = S_TAIL;
            end else if (hit_valid) begin
               // occupied by another key: step to the next slot
               h_in  = h_ff + HashBits'(1);
               raddr = h_ff + HashBits'(1);
            end else begin
               code_in  = prefix_ff;
               ret_in   = S_INSERT;
               state_in = S_PUT;
            end
         end
         S_INSERT: begin
            if (nfc_ff < 13'(MaxCodes)) begin
               mem_we = 1'b1;
               nfc_in = nfc_inc;
               if (nfc_inc > (13'd1 << width_ff) && width_ff < 4'(MaxWidth)) begin
                  width_in = width_ff + 4'd1;
               end
               prefix_in = 12'(k_ff);
               state_in  = S_TAIL;
            end else begin
               code_in  = 12'(clear_sym);
               ret_in   = S_RESTART;
               state_in = S_PUT;
            end
         end
         S_RESTART: begin
            nfc_in    = 13'(clear_sym) + 13'd2;
            width_in  = eff_min + 4'd1;
            prefix_in = 12'(k_ff);
            if (&epoch_ff) begin
               epoch_in    = TagBits'(1);
               clr_idx_in  = '0;
               clr_next_in = S_TAIL;
               state_in    = S_CLEAR;
            end else begin
               epoch_in = epoch_ff + TagBits'(1);
               state_in = S_TAIL;
            end
         end
         S_TAIL: begin
            if (last_ff) begin
               code_in  = prefix_ff;
               ret_in   = S_END1;
               state_in = S_PUT;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_END1: begin
            code_in  = 12'(clear_sym) + 12'd1;
            ret_in   = S_END2;
            fin_in   = 1'b1;
            state_in = S_PUT;
         end
         S_PUT: begin
            acc_in   = acc_ff | (AccBits'(code_ff) << cnt_ff);
            cnt_in   = cnt_ff + 5'(width_ff);
            state_in = S_DRAIN;
         end
         S_DRAIN: begin
            if (cnt_ff >= 5'd8) begin
               if (!out_full) begin
                  out_wr   = 1'b1;
                  out_word = '{code_byte: acc_ff[7:0],
                               last_byte: fin_ff && (cnt_ff == 5'd8)};
                  acc_in   = acc_ff >> 8;
                  cnt_in   = cnt_ff - 5'd8;
               end
            end else begin
               state_in = ret_ff;
            end
         end
         S_END2: begin
            if (cnt_ff == 5'd0 || !out_full) begin
               out_wr     = (cnt_ff != 5'd0);
               out_word   = '{code_byte: acc_ff[7:0], last_byte: 1'b1};
               acc_in     = '0;
               cnt_in     = '0;
               started_in = 1'b0;
               fin_in     = 1'b0;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      k_ff      <= k_in;
      h_ff      <= h_in;
      code_ff   <= code_in;
      ret_ff    <= ret_in;
      last_ff   <= last_in;
      prefix_ff <= prefix_in;
      acc_ff    <= acc_in;
      if (reset) begin
         state_ff    <= S_CLEAR;
         clr_next_ff <= S_IDLE;
         clr_idx_ff  <= '0;
         epoch_ff    <= TagBits'(1);
         min_ff      <= 4'd8;
         started_ff  <= 1'b0;
         fin_ff      <= 1'b0;
         nfc_ff      <= 13'd258;
         width_ff    <= 4'd9;
         cnt_ff      <= '0;
      end else begin
         state_ff    <= state_in;
         clr_next_ff <= clr_next_in;
         clr_idx_ff  <= clr_idx_in;
         epoch_ff    <= epoch_in;
         min_ff      <= min_in;
         started_ff  <= started_in;
         fin_ff      <= fin_in;
         nfc_ff      <= nfc_in;
         width_ff    <= width_in;
         cnt_ff      <= cnt_in;
      end
   end

endmodule
`default_nettype wire

### rtl/gif_lzw_encoder.sv
// Flow: a matched pixel word takes the dictionary engine through pop, probe and
// tail states, plus one extra probe per occupied slot; a miss adds an insert step
// and a put and drain per code sent. A new pixel is taken only back in idle.
// Reset: synchronous; after reset a clearing pass runs through all 8192 slots of
// the dictionary before the first pixel is taken, and again on every 255th
// dictionary restart.
`default_nettype none
// ----------------------------------------------------------------------------
// gif_lzw_encoder
// GIF variable-width LZW encoder, 12-bit codes, LSB-first byte packing.
// ----------------------------------------------------------------------------
module gif_lzw_encoder (
   input  wire                clock,
   input  wire                reset,
   input  wire                push,
   output logic               full,
   input  glz_pkg::req_type   req_item,
   output logic               empty,
   input  wire                pop,
   output glz_pkg::rsp_type   rsp_item,
   input  wire                csr_we,
   input  wire  [3:0]         csr_wdata
);
   import glz_pkg::*;

   item_type   item;
   rsp_type    out_word;
   logic       item_valid, item_pop, out_wr, out_full;
   logic [3:0] min_bits;

   glz_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (full),
      .req_item   (req_item),
      .min_bits   (min_bits),
      .item_valid (item_valid),
      .item_pop   (item_pop),
      .item       (item)
   );

   glz_back u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .min_bits   (min_bits),
      .item_valid (item_valid),
      .item_pop   (item_pop),
      .item       (item),
      .out_wr     (out_wr),
      .out_word   (out_word),
      .out_full   (out_full)
   );

   glz_out_fifo u_out (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (out_wr),
      .wr_word  (out_word),
      .wr_full  (out_full),
      .empty    (empty),
      .pop      (pop),
      .rsp_item (rsp_item)
   );

endmodule
`default_nettype wire
